/* rtl/core/scoped_fnv_id_stack_with_collisions_unit_assert.svh */
// Assertion macros for the scoped FNV id stack unit
`ifndef SCOPED_FNV_ID_STACK_WITH_COLLISIONS_UNIT_ASSERT_SVH
`define SCOPED_FNV_ID_STACK_WITH_COLLISIONS_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define FVS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fvs assertion failed");

// antecedent implies consequent in the next cycle
`define FVS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fvs assertion failed");

`endif

/* rtl/core/fvs_pkg.sv */
// Package: types, constants and hash helper for the scoped FNV id stack
`timescale 1ns / 1ps
`default_nettype none
package fvs_pkg;

  localparam int STACK_DEPTH_DEF     = 32;
  localparam int ISSUED_DEPTH_DEF    = 1024;
  localparam int COLLISION_DEPTH_DEF = 64;

  localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;

  // request op codes
  localparam logic [2:0] OP_BEGIN    = 3'd0;
  localparam logic [2:0] OP_PUSH_KEY = 3'd1;
  localparam logic [2:0] OP_PUSH_IDX = 3'd2;
  localparam logic [2:0] OP_POP      = 3'd3;
  localparam logic [2:0] OP_MAKE_KEY = 3'd4;
  localparam logic [2:0] OP_MAKE_IDX = 3'd5;

  typedef struct packed {
    logic [2:0]  op;
    logic [63:0] key_data;
    logic        last;
    logic        no_byte;
  } req_t;

  typedef struct packed {
    logic [63:0] id_value;
    logic        duplicate;
    logic        new_collision;
    logic [6:0]  collision_count;
    logic        table_full;
    logic        stack_overflow;
  } rsp_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;
    logic clear;
    logic key_absorb;
    logic idx_absorb;
    logic push;
    logic pop;
    logic pop_load;
    logic make;
    logic iss_init;
    logic iss_step;
    logic iss_add;
    logic col_init;
    logic col_step;
    logic col_add;
    logic emit;
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic last_idx_byte;
    logic iss_done;
    logic iss_found;
    logic col_done;
    logic col_found;
    logic track;
  } sts_t;

  // one FNV-1a step; the prime is 2^40 + 0x1B3, done as shifts and adds
  function automatic logic [63:0] fnv_absorb(input logic [63:0] h, input logic [7:0] b);
    logic [63:0] x;
    x = h ^ {56'd0, b};
    return x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
  endfunction

  function automatic logic [63:0] fold_zero(input logic [63:0] h);
    return (h == 64'd0) ? 64'd1 : h;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/fvs_ctrl.sv */
// Controller state machine for the scoped FNV id stack
`timescale 1ns / 1ps
`default_nettype none
module fvs_ctrl
  import fvs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [2:0] op,
  input  wire logic last,
  input  wire sts_t sts,
  output cmd_t      cmd,
  output logic      busy
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_CLR   = 10'b0000000010,
    S_KEY   = 10'b0000000100,
    S_HASH  = 10'b0000001000,
    S_PUSH  = 10'b0000010000,
    S_POP   = 10'b0000100000,
    S_POPLD = 10'b0001000000,
    S_MAKE  = 10'b0010000000,
    S_ISRCH = 10'b0100000000,
    S_CSRCH = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   mk, mk_next;
  logic   last_r, last_r_next;
  logic   emit_st, emit_st_next;

  assign busy = (state != S_IDLE) || emit_st;

  // next state and commands
  always_comb begin
    state_next   = state;
    mk_next      = mk;
    last_r_next  = last_r;
    emit_st_next = 1'b0;
    cmd          = '0;
    if (emit_st) begin
      cmd.emit = 1'b1;
    end
    case (state)
      S_IDLE: begin
        if (start && !emit_st) begin
          mk_next     = (op == OP_MAKE_KEY) || (op == OP_MAKE_IDX);
          last_r_next = last;
          case (op)
            OP_BEGIN: begin
              cmd.load = 1'b1; state_next = S_CLR;
            end
            OP_PUSH_KEY, OP_MAKE_KEY: begin
              cmd.load = 1'b1; state_next = S_KEY;
            end
            OP_PUSH_IDX, OP_MAKE_IDX: begin
              cmd.load = 1'b1; state_next = S_HASH;
            end
            OP_POP: begin
              cmd.load = 1'b1; state_next = S_POP;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1; emit_st_next = 1'b1; state_next = S_IDLE;
      end
      S_KEY: begin
        cmd.key_absorb = 1'b1;
        if (last_r) begin
          state_next = mk ? S_MAKE : S_PUSH;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_HASH: begin
        cmd.idx_absorb = 1'b1;
        if (sts.last_idx_byte) begin
          state_next = mk ? S_MAKE : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push = 1'b1; emit_st_next = 1'b1; state_next = S_IDLE;
      end
      S_POP: begin
        cmd.pop = 1'b1; state_next = S_POPLD;
      end
      S_POPLD: begin
        cmd.pop_load = 1'b1; emit_st_next = 1'b1; state_next = S_IDLE;
      end
      S_MAKE: begin
        cmd.make = 1'b1;
        if (sts.track) begin
          cmd.iss_init = 1'b1; state_next = S_ISRCH;
        end else begin
          emit_st_next = 1'b1; state_next = S_IDLE;
        end
      end
      S_ISRCH: begin
        if (!sts.iss_done) begin
          cmd.iss_step = 1'b1;
        end else if (sts.iss_found) begin
          cmd.col_init = 1'b1; state_next = S_CSRCH;
        end else begin
          cmd.iss_add = 1'b1; emit_st_next = 1'b1; state_next = S_IDLE;
        end
      end
      S_CSRCH: begin
        if (!sts.col_done) begin
          cmd.col_step = 1'b1;
        end else begin
          cmd.col_add  = !sts.col_found;
          emit_st_next = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      emit_st <= 1'b0;
    end else begin
      state   <= state_next;
      emit_st <= emit_st_next;
    end
    mk     <= mk_next;
    last_r <= last_r_next;
  end

endmodule
`default_nettype wire

/* rtl/core/fvs_dp.sv */
// Datapath: hash unit, scope stack, issued set and collision list
`timescale 1ns / 1ps
`default_nettype none
module fvs_dp
  import fvs_pkg::*;
#(
  parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
  parameter int ISSUED_DEPTH    = ISSUED_DEPTH_DEF,
  parameter int COLLISION_DEPTH = COLLISION_DEPTH_DEF
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req,
  input  wire logic wr_en,
  input  wire logic wr_data,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output logic      done,
  output rsp_t      rsp
);

  localparam int TW  = $clog2(STACK_DEPTH);
  localparam int DW  = $clog2(STACK_DEPTH + 1);
  localparam int IAW = $clog2(ISSUED_DEPTH);
  localparam int ICW = $clog2(ISSUED_DEPTH + 1);
  localparam int CAW = (COLLISION_DEPTH > 1) ? $clog2(COLLISION_DEPTH) : 1;
  localparam int CCW = $clog2(COLLISION_DEPTH + 1);

  // memories
  logic [63:0] stk_mem [STACK_DEPTH];
  logic [63:0] iss_mem [ISSUED_DEPTH];
  logic [63:0] col_mem [COLLISION_DEPTH];
  logic [63:0] stk_rdata, iss_rdata, col_rdata;

  // control state
  logic [DW-1:0]  depth;
  logic [ICW-1:0] iss_cnt, iss_idx;
  logic [CCW-1:0] col_cnt, col_idx;
  logic           iss_pend, iss_found, col_pend, col_found;
  logic           kip, track, pop_moved;
  logic [2:0]     bcnt;

  // payload
  logic [63:0] top, run, data_r, res;
  logic        nob_r, last_r;
  logic        dup, newc, full, ovf;

  logic [63:0] seed, key_h, cur;
  logic [DW-1:0] depth_m2;

  assign seed     = kip ? run : top;
  assign key_h    = nob_r ? seed : fnv_absorb(seed, data_r[7:0]);
  assign cur      = fold_zero(run);
  assign depth_m2 = depth - DW'(2);

  assign sts.last_idx_byte = (bcnt == 3'd7);
  assign sts.iss_done      = iss_found || (!iss_pend && (iss_idx >= iss_cnt));
  assign sts.iss_found     = iss_found;
  assign sts.col_done      = col_found || (!col_pend && (col_idx >= col_cnt));
  assign sts.col_found     = col_found;
  assign sts.track         = track;

  // scope stack memory; entry zero is never written, the root is a constant
  always_ff @(posedge clk) begin
    if (cmd.push && (depth < DW'(STACK_DEPTH))) begin
      stk_mem[depth[TW-1:0]] <= cur;
    end
    if (cmd.pop) begin
      stk_rdata <= stk_mem[depth_m2[TW-1:0]];
    end
  end

  // issued set memory
  always_ff @(posedge clk) begin
    if (cmd.iss_add && (iss_cnt < ICW'(ISSUED_DEPTH))) begin
      iss_mem[iss_cnt[IAW-1:0]] <= res;
    end
    if (cmd.iss_step && (iss_idx < iss_cnt)) begin
      iss_rdata <= iss_mem[iss_idx[IAW-1:0]];
    end
  end

  // collision list memory
  always_ff @(posedge clk) begin
    if (cmd.col_add && (col_cnt < CCW'(COLLISION_DEPTH))) begin
      col_mem[col_cnt[CAW-1:0]] <= res;
    end
    if (cmd.col_step && (col_idx < col_cnt)) begin
      col_rdata <= col_mem[col_idx[CAW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= DW'(1);
      iss_cnt   <= '0;
      col_cnt   <= '0;
      kip       <= 1'b0;
      track     <= 1'b1;
      done      <= 1'b0;
      iss_idx   <= '0;
      col_idx   <= '0;
      iss_pend  <= 1'b0;
      col_pend  <= 1'b0;
      iss_found <= 1'b0;
      col_found <= 1'b0;
      pop_moved <= 1'b0;
      bcnt      <= '0;
    end else begin
      done <= cmd.emit;
      if (wr_en) begin
        track <= wr_data;
      end
      if (cmd.load) begin
        if (req.op != OP_PUSH_KEY && req.op != OP_MAKE_KEY) begin
          kip <= 1'b0;
        end
        bcnt <= '0;
      end
      if (cmd.clear) begin
        depth   <= DW'(1);
        iss_cnt <= '0;
        col_cnt <= '0;
        kip     <= 1'b0;
      end
      if (cmd.key_absorb) begin
        kip <= !last_r;
      end
      if (cmd.idx_absorb) begin
        bcnt <= bcnt + 3'd1;
      end
      if (cmd.push && (depth < DW'(STACK_DEPTH))) begin
        depth <= depth + DW'(1);
      end
      if (cmd.pop) begin
        pop_moved <= (depth > DW'(1));
        if (depth > DW'(1)) begin
          depth <= depth - DW'(1);
        end
      end
      // issued set search, one read per cycle, compare in the following cycle
      if (cmd.iss_init) begin
        iss_idx <= '0; iss_pend <= 1'b0; iss_found <= 1'b0;
      end
      if (cmd.iss_step) begin
        iss_pend <= (iss_idx < iss_cnt);
        if (iss_idx < iss_cnt) begin
          iss_idx <= iss_idx + ICW'(1);
        end
        if (iss_pend && (iss_rdata == res)) begin
          iss_found <= 1'b1;
        end
      end
      if (cmd.iss_add && (iss_cnt < ICW'(ISSUED_DEPTH))) begin
        iss_cnt <= iss_cnt + ICW'(1);
      end
      // collision list search
      if (cmd.col_init) begin
        col_idx <= '0; col_pend <= 1'b0; col_found <= 1'b0;
      end
      if (cmd.col_step) begin
        col_pend <= (col_idx < col_cnt);
        if (col_idx < col_cnt) begin
          col_idx <= col_idx + CCW'(1);
        end
        if (col_pend && (col_rdata == res)) begin
          col_found <= 1'b1;
        end
      end
      if (cmd.col_add && (col_cnt < CCW'(COLLISION_DEPTH))) begin
        col_cnt <= col_cnt + CCW'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top <= FNV_BASIS;
    end else begin
      if (cmd.clear) begin
        top <= FNV_BASIS;
      end
      if (cmd.push && (depth < DW'(STACK_DEPTH))) begin
        top <= cur;
      end
      if (cmd.pop_load && pop_moved) begin
        top <= (depth == DW'(1)) ? FNV_BASIS : stk_rdata;
      end
    end
    if (cmd.load) begin
      data_r <= req.key_data;
      nob_r  <= req.no_byte;
      last_r <= req.last;
      dup    <= 1'b0;
      newc   <= 1'b0;
      full   <= 1'b0;
      ovf    <= 1'b0;
      if (req.op == OP_PUSH_IDX || req.op == OP_MAKE_IDX) begin
        run <= top;
      end
    end
    if (cmd.clear) begin
      res <= FNV_BASIS;
    end
    if (cmd.key_absorb) begin
      run <= key_h;
    end
    if (cmd.idx_absorb) begin
      run    <= fnv_absorb(run, data_r[7:0]);
      data_r <= data_r >> 8;
    end
    if (cmd.push) begin
      if (depth < DW'(STACK_DEPTH)) begin
        res <= cur;
      end else begin
        res <= top;
        ovf <= 1'b1;
      end
    end
    if (cmd.pop) begin
      res <= top;
    end
    if (cmd.pop_load && pop_moved) begin
      res <= (depth == DW'(1)) ? FNV_BASIS : stk_rdata;
    end
    if (cmd.make) begin
      res <= cur;
    end
    if (cmd.col_init) begin
      dup <= 1'b1;
    end
    if (cmd.iss_add && (iss_cnt >= ICW'(ISSUED_DEPTH))) begin
      full <= 1'b1;
    end
    if (cmd.col_add) begin
      if (col_cnt < CCW'(COLLISION_DEPTH)) begin
        newc <= 1'b1;
      end else begin
        full <= 1'b1;
      end
    end
    // result register
    if (cmd.emit) begin
      rsp.id_value        <= res;
      rsp.duplicate       <= dup;
      rsp.new_collision   <= newc;
      rsp.table_full      <= full;
      rsp.stack_overflow  <= ovf;
      rsp.collision_count <= (32'(col_cnt) > 32'd127) ? 7'd127 : 7'(col_cnt);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/scoped_fnv_id_stack_with_collisions_unit.sv */
// Sequence: begin clears, then emits; pop reads the stack, then loads the new top; a key byte
// is absorbed and, on the last byte, goes on to push or make; an index op absorbs eight bytes;
// make with tracking scans the issued ids, and on a repeat also the listed collisions.
// Throughput: one request at a time; the hash unit absorbs one byte per cycle and each
// store is scanned through its single read port. done pulses one cycle; no backpressure.
// Reset (rst, synchronous): stack holds only the root, sets empty, tracking on.
`timescale 1ns / 1ps
`default_nettype none
`include "scoped_fnv_id_stack_with_collisions_unit_assert.svh"
module scoped_fnv_id_stack_with_collisions_unit
  import fvs_pkg::*;
#(
  parameter int STACK_DEPTH     = STACK_DEPTH_DEF,
  parameter int ISSUED_DEPTH    = ISSUED_DEPTH_DEF,
  parameter int COLLISION_DEPTH = COLLISION_DEPTH_DEF
)(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req,
  output logic      done,
  output rsp_t      rsp,
  input  wire logic wr_en,
  input  wire logic wr_data
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  fvs_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .op   (req.op),
    .last (req.last),
    .sts  (sts),
    .cmd  (cmd),
    .busy (busy)
  );

  // hash, stack and tables
  fvs_dp #(
    .STACK_DEPTH    (STACK_DEPTH),
    .ISSUED_DEPTH   (ISSUED_DEPTH),
    .COLLISION_DEPTH(COLLISION_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .wr_en  (wr_en),
    .wr_data(wr_data),
    .cmd    (cmd),
    .sts    (sts),
    .done   (done),
    .rsp    (rsp)
  );

  // checks
  `FVS_ASSERT_SAME(a_done_after_busy, done, $past(busy))
  `FVS_ASSERT_NEXT(a_valid_req_busy, start && !busy && (req.op <= OP_MAKE_IDX), busy)
  `FVS_ASSERT_SAME(a_newc_is_dup, done && rsp.new_collision, rsp.duplicate)

endmodule
`default_nettype wire
